// ----- rtl/hsv_to_rgb565_converter_macros.svh -----
// assertion macros for the hsv to rgb565 converter checker
`ifndef HSV_TO_RGB565_CONVERTER_MACROS_SVH
`define HSV_TO_RGB565_CONVERTER_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define HSVRGB_ASSERT_NOW(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is held
`define HSVRGB_ASSERT_NEXT(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/hsvrgb_pkg.sv -----
// shared types and constants for the hsv to rgb565 converter
package hsvrgb_pkg;

	localparam int unsigned PCT_MAX     = 100;
	localparam int unsigned SECTOR_DEG  = 60;
	localparam int unsigned SECTOR_CNT  = 8;      // thresholds over the 9-bit hue range
	localparam int unsigned FULL_W      = 6000;   // 100 * 60, weight of the full value

	// floor(x / 600000) = floor((x >> 6) / 9375), the latter by reciprocal
	localparam int unsigned PRE_SHIFT   = 6;
	localparam int unsigned RECIP       = 916260; // ceil(2^33 / 9375)
	localparam int unsigned RECIP_SHIFT = 33;

	localparam int unsigned QUEUE_DEPTH_DEF = 4;

	// channel lanes
	localparam int unsigned LANE_CNT = 4;
	localparam int unsigned LANE_V   = 0;
	localparam int unsigned LANE_X   = 1;
	localparam int unsigned LANE_Y   = 2;
	localparam int unsigned LANE_Z   = 3;

	// hue sectors
	localparam logic [2:0] SEC_RED = 3'd0;
	localparam logic [2:0] SEC_YEL = 3'd1;
	localparam logic [2:0] SEC_GRN = 3'd2;
	localparam logic [2:0] SEC_CYN = 3'd3;
	localparam logic [2:0] SEC_BLU = 3'd4;
	localparam logic [2:0] SEC_MAG = 3'd5;

	typedef logic [12:0] weight_t;
	typedef logic [7:0]  chan_t;

	// classified word as it sits in the queue
	typedef struct packed {
		logic       black;
		logic [2:0] sector;
		logic [5:0] rem;
		logic [6:0] sat;
		logic [6:0] val;
	} cls_t;

endpackage

// ----- rtl/hsv_to_rgb565_converter.sv -----
// top level of the hsv to rgb565 converter
// usage:
//   input side is a queue write port: present hue (0..360 degrees), saturation and
//   brightness (0..100 percent, larger values count as 100) with push; a word is
//   taken on a rising edge with push high and full low
//   output side is a queue read port: while empty is low the oldest pixel is on
//   pixel (red 15..11, green 10..5, blue 4..0); it is taken on a rising edge with
//   pop high and empty low
// path: a pushed word passes through the queue, then the weight, product, quotient
//   and output registers (queue read, weights, products, divide and pack) to pixel
// throughput: one word per cycle sustained on both sides while pop is held high; the
//   pipeline and the output register advance together, so pop every cycle keeps it full
// stall: with pop held low the output register holds its word, the pipeline
//   stages fill behind it, then the queue fills and full rises
// reset: arst_n low empties the queue and all stages at once; full and empty
//   are low and high respectively straight after
// hue 360 or more with nonzero saturation gives black; zero saturation gives grey
module hsv_to_rgb565_converter
	import hsvrgb_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [8:0]  hue,
	input  logic [6:0]  saturation,
	input  logic [6:0]  brightness,
	input  logic        push,
	output logic        full,
	output logic [15:0] pixel,
	output logic        empty,
	input  logic        pop
);

	cls_t cls_in;     // classified word from the front end
	cls_t cls_out;    // oldest word in the queue
	logic q_valid;    // queue holds a word
	logic q_ready;    // back end takes a word

	// front: clamp and sector split
	hsvrgb_front u_front (
		.hue        (hue),
		.saturation (saturation),
		.brightness (brightness),
		.cls        (cls_in)
	);

	// decoupling queue
	hsvrgb_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (push),
		.wr_data  (cls_in),
		.full     (full),
		.rd_valid (q_valid),
		.rd_en    (q_ready),
		.rd_data  (cls_out)
	);

	// back: arithmetic pipeline and output register
	hsvrgb_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (q_valid),
		.in_ready (q_ready),
		.in_data  (cls_out),
		.pixel    (pixel),
		.empty    (empty),
		.pop      (pop)
	);

endmodule

// ----- rtl/hsvrgb_front.sv -----
// front end: clamps the inputs and splits the hue into sector and remainder
module hsvrgb_front
	import hsvrgb_pkg::*;
(
	input  logic [8:0] hue,
	input  logic [6:0] saturation,
	input  logic [6:0] brightness,
	output cls_t       cls
);

	logic [3:0] sector;
	logic [8:0] rem_full;
	logic [6:0] sat_cl;
	logic [6:0] val_cl;

	// sector is the number of 60 degree boundaries at or below the hue
	always_comb begin
		sector = '0;
		for (int k = 1; k <= int'(SECTOR_CNT); k++) begin
			if (hue >= 9'(SECTOR_DEG * k)) begin
				sector = sector + 4'd1;
			end
		end
	end

	assign rem_full = hue - 9'(sector) * 9'(SECTOR_DEG);
	assign sat_cl   = (saturation > 7'(PCT_MAX)) ? 7'(PCT_MAX) : saturation;
	assign val_cl   = (brightness > 7'(PCT_MAX)) ? 7'(PCT_MAX) : brightness;

	always_comb begin
		cls.black  = (sat_cl != '0) && (sector >= 4'd6);
		// zero saturation: every lane carries the value, so take the first sector
		cls.sector = (sat_cl == '0) ? SEC_RED : sector[2:0];
		cls.rem    = rem_full[5:0];
		cls.sat    = sat_cl;
		cls.val    = val_cl;
	end

endmodule

// ----- rtl/hsvrgb_queue.sv -----
// short word queue between the front end and the arithmetic pipeline
module hsvrgb_queue
	import hsvrgb_pkg::*;
#(
	parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  cls_t wr_data,
	output logic full,
	output logic rd_valid,
	input  logic rd_en,
	output cls_t rd_data
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	cls_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_wr;
	logic          do_rd;

	assign full     = (count_q == CW'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign do_wr    = wr_en && !full;
	assign do_rd    = rd_en && rd_valid;
	assign rd_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- rtl/hsvrgb_back.sv -----
// back end: weights, products, reciprocal divide, sector permutation, output word
module hsvrgb_back
	import hsvrgb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  cls_t        in_data,
	output logic [15:0] pixel,
	output logic        empty,
	input  logic        pop
);

	// stage valids and ready chain
	logic vld_s1, vld_s2, vld_s3, out_vld_q;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_out;

	// stage 1: channel weights
	weight_t    w_s1 [LANE_CNT];
	logic [6:0] val_s1;
	logic [2:0] sector_s1;
	logic       black_s1;

	// stage 2: value times weight
	logic [19:0] vw_s2 [LANE_CNT];
	logic [2:0]  sector_s2;
	logic        black_s2;

	// stage 3: quotients
	chan_t      q_s3 [LANE_CNT];
	logic [2:0] sector_s3;
	logic       black_s3;

	logic [15:0] pixel_q;

	weight_t     w_d [LANE_CNT];
	logic [12:0] s_r;
	logic [12:0] s_rc;
	logic [5:0]  rem_c;
	logic [27:0] p_d [LANE_CNT];
	logic [41:0] prod_d [LANE_CNT];
	chan_t       rc, gc, bc;

	assign rdy_out  = !out_vld_q || pop;
	assign rdy_s3   = !vld_s3 || rdy_out;
	assign rdy_s2   = !vld_s2 || rdy_s3;
	assign rdy_s1   = !vld_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	assign empty = !out_vld_q;
	assign pixel = pixel_q;

	// weights out of 6000: v, v(1-s), v(1-s f), v(1-s(1-f))
	assign rem_c = 6'(SECTOR_DEG) - in_data.rem;
	assign s_r   = 13'(in_data.sat) * 13'(in_data.rem);
	assign s_rc  = 13'(in_data.sat) * 13'(rem_c);

	always_comb begin
		w_d[LANE_V] = 13'(FULL_W);
		w_d[LANE_X] = 13'(SECTOR_DEG) * (13'(PCT_MAX) - 13'(in_data.sat));
		w_d[LANE_Y] = 13'(FULL_W) - s_r;
		w_d[LANE_Z] = 13'(FULL_W) - s_rc;
	end

	// 255 * vw, pre-shift, then reciprocal multiply by 1/9375
	always_comb begin
		for (int i = 0; i < int'(LANE_CNT); i++) begin
			p_d[i]    = {vw_s2[i], 8'd0} - 28'(vw_s2[i]);
			prod_d[i] = 42'(p_d[i][27:PRE_SHIFT]) * 42'(RECIP);
		end
	end

	// sector permutation
	always_comb begin
		rc = q_s3[LANE_V];
		gc = q_s3[LANE_V];
		bc = q_s3[LANE_V];
		unique case (sector_s3)
			SEC_RED: begin rc = q_s3[LANE_V]; gc = q_s3[LANE_Z]; bc = q_s3[LANE_X]; end
			SEC_YEL: begin rc = q_s3[LANE_Y]; gc = q_s3[LANE_V]; bc = q_s3[LANE_X]; end
			SEC_GRN: begin rc = q_s3[LANE_X]; gc = q_s3[LANE_V]; bc = q_s3[LANE_Z]; end
			SEC_CYN: begin rc = q_s3[LANE_X]; gc = q_s3[LANE_Y]; bc = q_s3[LANE_V]; end
			SEC_BLU: begin rc = q_s3[LANE_Z]; gc = q_s3[LANE_X]; bc = q_s3[LANE_V]; end
			SEC_MAG: begin rc = q_s3[LANE_V]; gc = q_s3[LANE_X]; bc = q_s3[LANE_Y]; end
			default: begin rc = '0; gc = '0; bc = '0; end
		endcase
		if (black_s3) begin
			rc = '0;
			gc = '0;
			bc = '0;
		end
	end

	// payload stages
	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			w_s1      <= w_d;
			val_s1    <= in_data.val;
			sector_s1 <= in_data.sector;
			black_s1  <= in_data.black;
		end
		if (rdy_s2) begin
			for (int i = 0; i < int'(LANE_CNT); i++) begin
				vw_s2[i] <= 20'(val_s1) * 20'(w_s1[i]);
			end
			sector_s2 <= sector_s1;
			black_s2  <= black_s1;
		end
		if (rdy_s3) begin
			for (int i = 0; i < int'(LANE_CNT); i++) begin
				q_s3[i] <= prod_d[i][RECIP_SHIFT +: 8];
			end
			sector_s3 <= sector_s2;
			black_s3  <= black_s2;
		end
		if (rdy_out) begin
			pixel_q <= {rc[7:3], gc[7:2], bc[7:3]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (rdy_s1) begin
				vld_s1 <= in_valid;
			end
			if (rdy_s2) begin
				vld_s2 <= vld_s1;
			end
			if (rdy_s3) begin
				vld_s3 <= vld_s2;
			end
			if (rdy_out) begin
				out_vld_q <= vld_s3;
			end
		end
	end

endmodule

// ----- rtl/hsvrgb_checker.sv -----
// port-level checker for the hsv to rgb565 converter, bound to the top level
`include "hsv_to_rgb565_converter_macros.svh"

module hsvrgb_checker
	import hsvrgb_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input logic        clk,
	input logic        arst_n,
	input logic        push,
	input logic        full,
	input logic [15:0] pixel,
	input logic        empty,
	input logic        pop
);

	localparam int unsigned MAX_HELD = QUEUE_DEPTH + 4;
	localparam int unsigned HW       = $clog2(MAX_HELD + 2) + 1;

	logic [HW-1:0] held_q;
	logic          push_acc;
	logic          pop_acc;

	assign push_acc = push && !full;
	assign pop_acc  = pop && !empty;

	// words accepted and not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else begin
			held_q <= held_q + HW'(push_acc) - HW'(pop_acc);
		end
	end

	`HSVRGB_ASSERT_NEXT(a_hold, clk, arst_n, !empty && !pop, !empty && $stable(pixel), "result word changed while stalled")
	`HSVRGB_ASSERT_NEXT(a_full_rise, clk, arst_n, !full && !push, !full, "full rose without a push")
	`HSVRGB_ASSERT_NOW(a_no_invent, clk, arst_n, !empty, held_q != '0, "result word shown with nothing accepted")
	`HSVRGB_ASSERT_NOW(a_bounded, clk, arst_n, 1'b1, held_q <= HW'(MAX_HELD), "more words held than the block can store")

endmodule

bind hsv_to_rgb565_converter hsvrgb_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_chk (.*);
